[rtl/core/gpd_pkg.sv]
// Shared constants and types for the graph path search block.
`timescale 1ns / 1ps
`default_nettype none
package gpd_pkg;

  localparam int unsigned NUM_VTX = 32;
  localparam int unsigned VTX_W   = $clog2(NUM_VTX);
  localparam int unsigned CNT_W   = $clog2(NUM_VTX) + 1;

  typedef logic [VTX_W-1:0]   vtx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [NUM_VTX-1:0] row_t;

  typedef enum logic {
    REQ_ADD  = 1'b0,
    REQ_FIND = 1'b1
  } req_e;

endpackage
`default_nettype wire

[rtl/core/gpd_if.sv]
// Request and result channel interfaces of the graph path search block.
`timescale 1ns / 1ps
`default_nettype none
interface gpd_req_if
  import gpd_pkg::*;
();
  logic valid;
  logic ready;
  logic req_type;
  vtx_t vertex_a;
  vtx_t vertex_b;

  modport source (output valid, output req_type, output vertex_a, output vertex_b,
                  input ready);
  modport sink   (input valid, input req_type, input vertex_a, input vertex_b,
                  output ready);
endinterface

interface gpd_res_if
  import gpd_pkg::*;
();
  logic valid;
  logic ready;
  vtx_t path_vertex;
  logic found;
  logic last;

  modport source (output valid, output path_vertex, output found, output last,
                  input ready);
  modport sink   (input valid, input path_vertex, input found, input last,
                  output ready);
endinterface
`default_nettype wire

[rtl/core/graph_path_dfs.sv]
// Graph path search: adjacency memory, explicit DFS stack memory, result register.
//
//  channel   direction  transaction
//  --------  ---------  ---------------------------------------------
//  req_i     in         req_type, vertex_a, vertex_b
//  res_o     out        path_vertex, found, last
//  cfg       in         cfg_we_i / cfg_wdata_i -> vertex_count
//
// One request at a time. An edge insert is a read-modify-write of two adjacency
// rows (read row a; write row a and read row b; write row b). In a search, a
// pop reads the stack memory, then the adjacency memory. Results then follow
// at one per cycle while res_o is ready.
// Reset clears adjacency row valid bits at once; no clearing pass is needed.
// A stalled res_o holds the result register and pauses the search at its next emit.
`timescale 1ns / 1ps
`default_nettype none
module graph_path_dfs
  import gpd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire cnt_t       cfg_wdata_i,
  gpd_req_if.sink         req_i,
  gpd_res_if.source       res_o
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_EA   = 10'b0000000010,
    S_EB   = 10'b0000000100,
    S_CHK  = 10'b0000001000,
    S_SCAN = 10'b0000010000,
    S_POP  = 10'b0000100000,
    S_FAIL = 10'b0001000000,
    S_HIT  = 10'b0010000000,
    S_TOP  = 10'b0100000000,
    S_WALK = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  cnt_t   vc_q;
  cnt_t   n_eff;
  row_t   nmask;
  vtx_t   va_q, va_d, vb_q, vb_d;
  vtx_t   cur_v_q, cur_v_d;
  cnt_t   depth_q, depth_d;
  cnt_t   stk_lo, stk_hi;
  row_t   visited_q, visited_d;

  row_t   adj_mem [NUM_VTX];
  row_t   adj_vld_q;
  row_t   adj_rdata_q;
  logic   adj_rvld_q;
  logic   adj_re, adj_we;
  vtx_t   adj_raddr, adj_waddr;
  row_t   adj_wdata;
  row_t   adj_row;

  vtx_t   stk_mem [NUM_VTX];
  vtx_t   stk_rdata_q;
  logic   stk_re, stk_we;
  vtx_t   stk_raddr, stk_waddr;
  vtx_t   stk_wdata;

  row_t   cand;
  vtx_t   hit_idx;

  logic   out_vld_q, out_vld_d;
  vtx_t   out_vtx_q, out_vtx_d;
  logic   out_fnd_q, out_fnd_d;
  logic   out_lst_q, out_lst_d;
  logic   out_free;
  logic   find_bad;

  // effective vertex count and in-range mask
  always_comb begin
    n_eff = (vc_q > CNT_W'(NUM_VTX)) ? CNT_W'(NUM_VTX) : vc_q;
    for (int j = 0; j < NUM_VTX; j++) begin
      nmask[j] = (CNT_W'(j) < n_eff);
    end
  end

  assign adj_row = adj_rvld_q ? adj_rdata_q : '0;
  assign cand    = adj_row & ~visited_q & nmask;

  always_comb begin
    hit_idx = '0;
    for (int j = NUM_VTX - 1; j >= 0; j--) begin
      if (cand[j]) hit_idx = VTX_W'(j);
    end
  end

  assign stk_lo   = depth_q - CNT_W'(2);
  assign stk_hi   = depth_q - CNT_W'(1);
  assign out_free = !out_vld_q || res_o.ready;
  assign find_bad = !({1'b0, va_q} < n_eff) || !({1'b0, vb_q} < n_eff);

  always_comb begin
    state_d   = state_q;
    va_d      = va_q;
    vb_d      = vb_q;
    cur_v_d   = cur_v_q;
    depth_d   = depth_q;
    visited_d = visited_q;
    adj_re    = 1'b0;
    adj_raddr = '0;
    adj_we    = 1'b0;
    adj_waddr = '0;
    adj_wdata = '0;
    stk_re    = 1'b0;
    stk_raddr = '0;
    stk_we    = 1'b0;
    stk_waddr = '0;
    stk_wdata = '0;
    out_vld_d = out_vld_q && !res_o.ready;
    out_vtx_d = out_vtx_q;
    out_fnd_d = out_fnd_q;
    out_lst_d = out_lst_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          va_d = req_i.vertex_a;
          vb_d = req_i.vertex_b;
          if (req_i.req_type == REQ_FIND) begin
            state_d = S_CHK;
          end else if (({1'b0, req_i.vertex_a} < n_eff) &&
                       ({1'b0, req_i.vertex_b} < n_eff)) begin
            adj_re    = 1'b1;
            adj_raddr = req_i.vertex_a;
            state_d   = S_EA;
          end
        end
      end
      S_EA: begin
        adj_we    = 1'b1;
        adj_waddr = va_q;
        adj_wdata = adj_row | (row_t'(1) << vb_q);
        adj_re    = 1'b1;
        adj_raddr = vb_q;
        state_d   = S_EB;
      end
      S_EB: begin
        adj_we    = 1'b1;
        adj_waddr = vb_q;
        adj_wdata = adj_row | (row_t'(1) << va_q);
        state_d   = S_IDLE;
      end
      S_CHK: begin
        if (find_bad) begin
          if (out_free) begin
            out_vld_d = 1'b1;
            out_vtx_d = '0;
            out_fnd_d = 1'b0;
            out_lst_d = 1'b1;
            state_d   = S_IDLE;
          end
        end else if (va_q == vb_q) begin
          if (out_free) begin
            out_vld_d = 1'b1;
            out_vtx_d = vb_q;
            out_fnd_d = 1'b1;
            out_lst_d = 1'b1;
            state_d   = S_IDLE;
          end
        end else begin
          visited_d = row_t'(1) << va_q;
          cur_v_d   = va_q;
          depth_d   = CNT_W'(1);
          adj_re    = 1'b1;
          adj_raddr = va_q;
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cand == '0) begin
          if (depth_q == CNT_W'(1)) begin
            state_d = S_FAIL;
          end else begin
            stk_re    = 1'b1;
            stk_raddr = stk_lo[VTX_W-1:0];
            depth_d   = stk_hi;
            state_d   = S_POP;
          end
        end else if (hit_idx == vb_q) begin
          state_d = S_HIT;
        end else begin
          stk_we    = 1'b1;
          stk_waddr = stk_hi[VTX_W-1:0];
          stk_wdata = cur_v_q;
          cur_v_d   = hit_idx;
          visited_d = visited_q | (row_t'(1) << hit_idx);
          depth_d   = depth_q + CNT_W'(1);
          adj_re    = 1'b1;
          adj_raddr = hit_idx;
        end
      end
      S_POP: begin
        cur_v_d   = stk_rdata_q;
        adj_re    = 1'b1;
        adj_raddr = stk_rdata_q;
        state_d   = S_SCAN;
      end
      S_FAIL: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_vtx_d = '0;
          out_fnd_d = 1'b0;
          out_lst_d = 1'b1;
          depth_d   = '0;
          state_d   = S_IDLE;
        end
      end
      S_HIT: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_vtx_d = vb_q;
          out_fnd_d = 1'b1;
          out_lst_d = 1'b0;
          state_d   = S_TOP;
        end
      end
      S_TOP, S_WALK: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_vtx_d = (state_q == S_TOP) ? cur_v_q : stk_rdata_q;
          out_fnd_d = 1'b1;
          out_lst_d = (depth_q == CNT_W'(1));
          if (depth_q == CNT_W'(1)) begin
            depth_d = '0;
            state_d = S_IDLE;
          end else begin
            stk_re    = 1'b1;
            stk_raddr = stk_lo[VTX_W-1:0];
            depth_d   = stk_hi;
            state_d   = S_WALK;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // adjacency memory
  always_ff @(posedge clk_i) begin
    if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
    if (adj_re) adj_rdata_q <= adj_mem[adj_raddr];
  end

  // stack memory
  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (stk_re) stk_rdata_q <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_vld_q  <= '0;
      adj_rvld_q <= 1'b0;
    end else begin
      if (adj_re) adj_rvld_q <= adj_vld_q[adj_raddr];
      if (adj_we) adj_vld_q[adj_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      vc_q      <= CNT_W'(NUM_VTX);
      depth_q   <= '0;
      visited_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      depth_q   <= depth_d;
      visited_q <= visited_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) vc_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    va_q      <= va_d;
    vb_q      <= vb_d;
    cur_v_q   <= cur_v_d;
    out_vtx_q <= out_vtx_d;
    out_fnd_q <= out_fnd_d;
    out_lst_q <= out_lst_d;
  end

  assign req_i.ready       = (state_q == S_IDLE);
  assign res_o.valid       = out_vld_q;
  assign res_o.path_vertex = out_vtx_q;
  assign res_o.found       = out_fnd_q;
  assign res_o.last        = out_lst_q;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= CNT_W'(NUM_VTX))
    else $error("stack depth beyond vertex count");

  a_top_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> visited_q[cur_v_q])
    else $error("stack top not marked visited");

  a_fail_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_fnd_q) |-> (out_lst_q && out_vtx_q == '0))
    else $error("failed search result malformed");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (depth_q == '0))
    else $error("stack not empty between requests");

endmodule
`default_nettype wire

[verif/graph_path_dfs_test.sv]
// Self-checking testbench for the graph path search block, with its own DFS path predictor.
`timescale 1ns / 1ps
module graph_path_dfs_test
  import gpd_pkg::*;
;

  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned NUM_PHASES    = 7;
  localparam int unsigned ITEMS_PER_RUN = 19;

  typedef struct packed {
    req_e kind;
    vtx_t vertex_a;
    vtx_t vertex_b;
  } graph_req_t;

  typedef struct packed {
    vtx_t path_vertex;
    logic found;
    logic last;
  } path_step_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  cnt_t cfg_wdata_i;

  gpd_req_if req_ch ();
  gpd_res_if res_ch ();

  graph_path_dfs i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_ch),
    .res_o       (res_ch)
  );

  graph_req_t  pending_requests[$];
  path_step_t  expected_path[$];
  row_t        adj_rows [NUM_VTX];
  cnt_t        vcount_model;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned req_gap_left;
  int unsigned res_hold_left;
  bit          idle_on;

  function automatic void queue_step(vtx_t v, logic f, logic l);
    path_step_t step;
    step = '{path_vertex: v, found: f, last: l};
    expected_path.insert(expected_path.size(), step);
  endfunction

  function automatic void search_path(req_e kind, vtx_t src, vtx_t dst);
    int unsigned n;
    row_t        seen;
    vtx_t        stack_vtx [NUM_VTX];
    int unsigned stack_next [NUM_VTX];
    int unsigned depth;
    int unsigned top;
    int unsigned v;
    int unsigned i;
    bit          hit;
    bit          stepped;
    bit          pushed;
    n = (vcount_model < NUM_VTX) ? vcount_model : NUM_VTX;
    if (kind == REQ_ADD) begin
      if (src < n && dst < n) begin
        adj_rows[src][dst] = 1'b1;
        adj_rows[dst][src] = 1'b1;
      end
    end else if (src >= n || dst >= n) begin
      queue_step('0, 1'b0, 1'b1);
    end else if (src == dst) begin
      queue_step(dst, 1'b1, 1'b1);
    end else begin
      seen          = '0;
      seen[src]     = 1'b1;
      stack_vtx[0]  = src;
      stack_next[0] = 0;
      depth         = 1;
      hit           = 1'b0;
      while (depth > 0 && !hit) begin
        top     = depth - 1;
        v       = stack_vtx[top];
        i       = stack_next[top];
        stepped = 1'b0;
        pushed  = 1'b0;
        while (i < n && !stepped) begin
          if (adj_rows[v][i] && !seen[i]) begin
            stepped = 1'b1;
            if (i == dst) begin
              hit = 1'b1;
            end else begin
              stack_next[top] = i + 1;
              if (depth < NUM_VTX) begin
                seen[i]           = 1'b1;
                stack_vtx[depth]  = vtx_t'(i);
                stack_next[depth] = 0;
                depth++;
                pushed = 1'b1;
              end
            end
          end else begin
            i++;
          end
        end
        if (!pushed && i >= n) depth--;
      end
      if (hit) begin
        queue_step(dst, 1'b1, 1'b0);
        for (int d = depth; d > 0; d--) begin
          queue_step(stack_vtx[d-1], 1'b1, logic'(d == 1));
        end
      end else begin
        queue_step('0, 1'b0, 1'b1);
      end
    end
  endfunction

  function automatic vtx_t pick_vertex(int unsigned n);
    if (n == 0 || $urandom_range(0, 9) == 0) return vtx_t'($urandom_range(0, NUM_VTX - 1));
    return vtx_t'($urandom_range(0, (n < NUM_VTX ? n : NUM_VTX) - 1));
  endfunction

  task automatic add_request(req_e kind, vtx_t a, vtx_t b);
    graph_req_t entry;
    entry = '{kind: kind, vertex_a: a, vertex_b: b};
    pending_requests.insert(pending_requests.size(), entry);
  endtask

  task automatic write_vertex_count(cnt_t value);
    @(posedge clk_i);
    cfg_we_i     <= 1'b1;
    cfg_wdata_i  <= value;
    vcount_model  = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain;
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || req_ch.valid || expected_path.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // driver: one transaction per handshake, predicted on acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready) begin
        search_path(req_e'(req_ch.req_type), req_ch.vertex_a, req_ch.vertex_b);
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (req_gap_left > 0) begin
          req_ch.valid <= 1'b0;
          req_gap_left--;
        end else if (idle_on && pending_requests.size() != 0 && $urandom_range(0, 4) == 0) begin
          req_ch.valid <= 1'b0;
          req_gap_left = $urandom_range(0, 3);
        end else if (pending_requests.size() != 0) begin
          graph_req_t next_req;
          next_req = pending_requests.pop_front();
          req_ch.valid    <= 1'b1;
          req_ch.req_type <= next_req.kind;
          req_ch.vertex_a <= next_req.vertex_a;
          req_ch.vertex_b <= next_req.vertex_b;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin : res_monitor
    path_step_t want;
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_path.size() == 0) begin
          $error("unexpected result: path_vertex %0d found %0d last %0d",
                 res_ch.path_vertex, res_ch.found, res_ch.last);
          mismatch_count++;
        end else begin
          want = expected_path.pop_front();
          if (res_ch.path_vertex !== want.path_vertex) begin
            $error("path_vertex: expected %0d, got %0d", want.path_vertex, res_ch.path_vertex);
            mismatch_count++;
          end
          if (res_ch.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, res_ch.found);
            mismatch_count++;
          end
          if (res_ch.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, res_ch.last);
            mismatch_count++;
          end
        end
      end
      if (res_hold_left > 0) begin
        res_ch.ready <= 1'b0;
        res_hold_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        res_ch.ready <= 1'b0;
        res_hold_left = $urandom_range(0, 3);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    cnt_t        phase_counts [NUM_PHASES];
    int unsigned n;
    req_e        kind;
    phase_counts = '{6'd0, 6'd1, 6'd63, 6'd2, 6'd6, 6'd12, 6'd32};
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_ADD;
    req_ch.vertex_a = '0;
    req_ch.vertex_b = '0;
    res_ch.ready    = 1'b0;
    vcount_model    = cnt_t'(NUM_VTX);
    mismatch_count  = 0;
    cycle_count     = 0;
    req_gap_left    = 0;
    res_hold_left   = 0;
    idle_on         = 1'b1;
    foreach (adj_rows[k]) adj_rows[k] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty graph, trivial search, a chain with a detour, self loop
    add_request(REQ_FIND, 5'd0, 5'd31);
    add_request(REQ_FIND, 5'd5, 5'd5);
    add_request(REQ_ADD, 5'd0, 5'd1);
    add_request(REQ_ADD, 5'd1, 5'd2);
    add_request(REQ_ADD, 5'd2, 5'd3);
    add_request(REQ_ADD, 5'd3, 5'd31);
    add_request(REQ_ADD, 5'd0, 5'd16);
    add_request(REQ_ADD, 5'd16, 5'd31);
    add_request(REQ_ADD, 5'd7, 5'd7);
    add_request(REQ_FIND, 5'd0, 5'd31);
    add_request(REQ_FIND, 5'd31, 5'd0);
    add_request(REQ_FIND, 5'd16, 5'd2);
    add_request(REQ_FIND, 5'd7, 5'd8);
    add_request(REQ_FIND, 5'd7, 5'd7);
    add_request(REQ_ADD, 5'd21, 5'd10);
    add_request(REQ_FIND, 5'd10, 5'd21);
    add_request(REQ_FIND, 5'd21, 5'd10);
    add_request(REQ_FIND, 5'd31, 5'd31);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_on = (p != 3) && (p != NUM_PHASES - 1);
      write_vertex_count(phase_counts[p]);
      n = (phase_counts[p] < NUM_VTX) ? phase_counts[p] : NUM_VTX;
      for (int k = 0; k < ITEMS_PER_RUN; k++) begin
        kind = ($urandom_range(0, 99) < 55) ? REQ_ADD : REQ_FIND;
        add_request(kind, pick_vertex(n), pick_vertex(n));
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
